FILE: rtl/core/lcd_pkg.sv
// ---------------------------------------------------------------------------
// lcd_pkg
// Shared types and constants of the line command decoder: keyword table,
// character codes and the queue entry between front and back.
// ---------------------------------------------------------------------------
package lcd_pkg;

  localparam int KW_COUNT     = 16;
  localparam int KW_ARG_COUNT = 10;
  localparam int KW_MAX_LEN   = 7;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [31:0] ARG_MAX    = 32'h7FFF_FFFF;
  localparam logic [35:0] ARG_MAG_LIM = 36'h0_8000_0000;

  // Keyword text, left aligned, padded with zero bytes.
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    {"M1POS",   16'h0}, {"M2POS",   16'h0}, {"M1SPD",   16'h0},
    {"M2SPD",   16'h0}, {"M1MODE",  8'h0},  {"M2MODE",  8'h0},
    {"M1ADD",   16'h0}, {"M1SUB",   16'h0}, {"M2ADD",   16'h0},
    {"M2SUB",   16'h0}, {"ENABLE",  8'h0},  {"DISABLE"},
    {"SAVE",    24'h0}, {"ZERO",    24'h0}, {"STATUS",  8'h0},
    {"HOME",    24'h0}
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd6, 3'd7, 3'd4, 3'd4, 3'd6, 3'd4
  };

  typedef struct packed {
    logic       eol;
    logic [7:0] data;
  } qent_t;

  function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
    int sh;
    sh = 8 * (KW_MAX_LEN - 1 - int'(p));
    return KW_TEXT[k][sh +: 8];
  endfunction

endpackage

FILE: rtl/core/lcd_fifo.sv
// ---------------------------------------------------------------------------
// lcd_fifo
// Short queue of classified items between the front and the back.
// ---------------------------------------------------------------------------
module lcd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lcd_pkg::qent_t push_data,
  output logic          full,
  input  logic          pop,
  output lcd_pkg::qent_t pop_data,
  output logic          empty
);
  import lcd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  qent_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;

  assign full     = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: rtl/core/lcd_front.sv
// ---------------------------------------------------------------------------
// lcd_front
// Accepts received bytes, tracks the line fill, drops overflow bytes and
// empty line ends, and queues the rest for the back.
// ---------------------------------------------------------------------------
module lcd_front #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_rx_byte,
  input  logic           q_full,
  output logic           q_push,
  output lcd_pkg::qent_t q_data
);
  import lcd_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

  logic [LEN_W-1:0] count_r;
  logic             is_eol, keep, take;

  assign is_eol   = (in_rx_byte == CH_CR) || (in_rx_byte == CH_LF);
  assign keep     = is_eol ? (count_r != '0) : (count_r < LEN_MAX);
  assign in_stall = q_full;
  assign take     = in_valid && !q_full;
  assign q_push   = take && keep;
  assign q_data   = '{eol: is_eol, data: in_rx_byte};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (take) begin
      if (is_eol) begin
        count_r <= '0;
      end else if (keep) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/lcd_back.sv
// ---------------------------------------------------------------------------
// lcd_back
// Stores line bytes, and at a line end walks the stored line: keyword match
// over the first characters, then the decimal argument for keywords that take
// one. Holds the result in an output register.
// ---------------------------------------------------------------------------
module lcd_back #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  lcd_pkg::qent_t      q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_command_code,
  output logic signed [31:0]  out_argument
);
  import lcd_pkg::*;

  localparam int DEPTH  = LINE_CAPACITY - 1;
  localparam int LEN_W  = $clog2(LINE_CAPACITY);
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MRD  = 3'd1;
  localparam logic [2:0] S_MEV  = 3'd2;
  localparam logic [2:0] S_PICK = 3'd3;
  localparam logic [2:0] S_ARD  = 3'd4;
  localparam logic [2:0] S_AEV  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic A_LEAD   = 1'b0;
  localparam logic A_DIGITS = 1'b1;

  logic [7:0]          line_mem [DEPTH];
  logic [7:0]          rd_data_r;

  logic [2:0]          state_r, state_nxt;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    pos_r, pos_nxt;
  logic [KW_COUNT-1:0] alive_r, alive_nxt;
  logic [KW_COUNT-1:0] hit_r, hit_nxt;
  logic [3:0]          code_r, code_nxt;
  logic                aph_r, aph_nxt;
  logic                neg_r, neg_nxt;
  logic [31:0]         mag_r, mag_nxt;
  logic [31:0]         arg_r, arg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [3:0]          out_code_r, out_code_nxt;
  logic [31:0]         out_arg_r, out_arg_nxt;

  logic                at_end, is_digit, is_blank, is_sign;
  logic [LEN_W-1:0]    klen;
  logic [35:0]         mag_next;
  logic [31:0]         arg_final;
  logic                found;
  logic [3:0]          sel;

  assign q_pop            = (state_r == S_IDLE) && !q_empty;
  assign out_valid        = out_valid_r;
  assign out_command_code = out_code_r;
  assign out_argument     = out_arg_r;

  assign at_end   = (pos_r >= len_r) || (rd_data_r == CH_NUL);
  assign is_digit = (rd_data_r >= CH_ZERO) && (rd_data_r <= CH_NINE);
  assign is_blank = (rd_data_r == CH_SPACE) || ((rd_data_r >= CH_TAB) && (rd_data_r <= CH_CR));
  assign is_sign  = (rd_data_r == CH_PLUS) || (rd_data_r == CH_MINUS);

  // mag*10 + digit, by shift and add
  assign mag_next = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1)
                  + {32'b0, rd_data_r[3:0] - CH_ZERO[3:0]};

  assign arg_final = neg_r ? (32'd0 - mag_r) : (mag_r[31] ? ARG_MAX : mag_r);

  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (hit_r[i]) begin
        found = 1'b1;
        sel   = 4'(i);
      end
    end
  end

  // Line store and its registered read port
  always_ff @(posedge clk) begin
    if (q_pop && !q_data.eol) begin
      line_mem[len_r[ADDR_W-1:0]] <= q_data.data;
    end
    if (pos_r < LEN_W'(DEPTH)) begin
      rd_data_r <= line_mem[pos_r[ADDR_W-1:0]];
    end else begin
      rd_data_r <= CH_NUL;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    alive_nxt     = alive_r;
    hit_nxt       = hit_r;
    code_nxt      = code_r;
    aph_nxt       = aph_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    arg_nxt       = arg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_code_nxt  = out_code_r;
    out_arg_nxt   = out_arg_r;
    klen          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          if (q_data.eol) begin
            pos_nxt   = '0;
            alive_nxt = '1;
            hit_nxt   = '0;
            state_nxt = S_MRD;
          end else begin
            len_nxt = len_r + 1'b1;
          end
        end
      end
      S_MRD: state_nxt = S_MEV;
      S_MEV: begin
        for (int k = 0; k < KW_COUNT; k++) begin
          klen = LEN_W'(KW_LEN[k]);
          if (pos_r < klen) begin
            alive_nxt[k] = alive_r[k] && !at_end && (rd_data_r == kw_char(k, pos_r[2:0]));
          end else if (pos_r == klen) begin
            if (alive_r[k] && ((k < KW_ARG_COUNT) || at_end)) begin
              hit_nxt[k] = 1'b1;
            end
          end
        end
        if (at_end || (pos_r == LEN_W'(KW_MAX_LEN))) begin
          state_nxt = S_PICK;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_MRD;
        end
      end
      S_PICK: begin
        code_nxt = sel;
        if (!found) begin
          len_nxt   = '0;
          state_nxt = S_IDLE;
        end else if (int'(sel) < KW_ARG_COUNT) begin
          pos_nxt   = LEN_W'(KW_LEN[sel]);
          aph_nxt   = A_LEAD;
          neg_nxt   = 1'b0;
          mag_nxt   = '0;
          state_nxt = S_ARD;
        end else begin
          arg_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end
      S_ARD: state_nxt = S_AEV;
      S_AEV: begin
        state_nxt = S_ARD;
        if (at_end) begin
          arg_nxt   = arg_final;
          state_nxt = S_EMIT;
        end else if (is_digit) begin
          mag_nxt = (mag_next > ARG_MAG_LIM) ? ARG_MAG_LIM[31:0] : mag_next[31:0];
          aph_nxt = A_DIGITS;
          pos_nxt = pos_r + 1'b1;
        end else if ((aph_r == A_LEAD) && is_blank) begin
          pos_nxt = pos_r + 1'b1;
        end else if ((aph_r == A_LEAD) && is_sign) begin
          neg_nxt = (rd_data_r == CH_MINUS);
          aph_nxt = A_DIGITS;
          pos_nxt = pos_r + 1'b1;
        end else begin
          arg_nxt   = arg_final;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = code_r;
          out_arg_nxt   = arg_r;
          len_nxt       = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    alive_r    <= alive_nxt;
    hit_r      <= hit_nxt;
    code_r     <= code_nxt;
    aph_r      <= aph_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    arg_r      <= arg_nxt;
    out_code_r <= out_code_nxt;
    out_arg_r  <= out_arg_nxt;
  end

endmodule

FILE: rtl/core/line_command_decoder.sv
// ---------------------------------------------------------------------------
// line_command_decoder
// Collects received bytes into a line and decodes keyword commands with a
// signed decimal argument at each line end.
// ---------------------------------------------------------------------------
//  channel  ports                                  role
//  input    in_valid, in_stall, in_rx_byte         one received byte per item
//  result   out_valid, out_stall,                  one decoded command per
//           out_command_code, out_argument         recognised line
//
//  A byte is taken into a four-entry queue; the back stores each queued line
//  byte in its line store. At a line end the back walks the line store one
//  character at a time (one memory read port, registered): up to eight
//  characters for the keyword match and then the argument. Reset (rst_n low,
//  synchronous) empties the line and the queue; no clearing pass. in_stall
//  rises only when the queue is full; a stalled result holds in its output
//  register while bytes keep entering the queue.
// ---------------------------------------------------------------------------
module line_command_decoder #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_command_code,
  output logic signed [31:0] out_argument
);
  import lcd_pkg::*;

  qent_t push_data, pop_data;
  logic  push, pop, full, empty;

  lcd_front #(.LINE_CAPACITY(LINE_CAPACITY)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .q_full     (full),
    .q_push     (push),
    .q_data     (push_data)
  );

  lcd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  lcd_back #(.LINE_CAPACITY(LINE_CAPACITY)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (empty),
    .q_data           (pop_data),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command_code (out_command_code),
    .out_argument     (out_argument)
  );

endmodule
